FILE: rtl/sje_pkg.sv
package sje_pkg;

	// Data and iteration configuration
	localparam int DATA_WIDTH    = 32;
	localparam int CORDIC_STAGES = 24;

	// Angle format and fixed constants, Q2.30
	localparam int FRAC_ANG = 30;
	localparam logic signed [33:0] ANG_PI4     = 34'sd843314857;
	localparam logic signed [33:0] CORDIC_KINV = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

	// Normalized vectoring operands peak just below 2^57; growth stays under 2^60
	localparam int NORM_MSB = 56;
	localparam int VW       = 61;
	// Angle accumulator and rotation datapath width
	localparam int ZW       = 34;
	// Magnitude width of |a-d| and |2b|
	localparam int MW       = DATA_WIDTH + 1;
	localparam int SHW      = 6;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] a;
		logic signed [DATA_WIDTH-1:0] b;
		logic signed [DATA_WIDTH-1:0] d;
	} mat_t;

	// atan(2^-i) in Q2.30, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
		logic signed [ZW-1:0] r;
		r = '0;
		case (i)
			0:       r = 34'sd843314857;
			1:       r = 34'sd497837829;
			2:       r = 34'sd263043837;
			3:       r = 34'sd133525159;
			4:       r = 34'sd67021687;
			5:       r = 34'sd33543516;
			6:       r = 34'sd16775851;
			7:       r = 34'sd8388437;
			8:       r = 34'sd4194283;
			9:       r = 34'sd2097149;
			default: begin
				if (i <= 30) r = ZW'(64'sd1 <<< (30 - i));
				else r = '0;
			end
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/symmetric_2x2_eigen_solver.sv
// Eigen-decomposition of a symmetric 2x2 matrix by one Jacobi rotation. One matrix
// transaction may be issued on every clock; busy is always low. The result appears
// for one cycle with done, after the two CORDIC pipelines (vectoring for the angle,
// rotation for cos/sin) plus normalize, multiply and ordering stages. Results cannot
// be held off and must be captured on the done cycle.
module symmetric_2x2_eigen_solver (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [sje_pkg::DATA_WIDTH-1:0] entry_a,
	input  logic signed [sje_pkg::DATA_WIDTH-1:0] entry_b,
	input  logic signed [sje_pkg::DATA_WIDTH-1:0] entry_d,
	output logic                                  done,
	output logic signed [sje_pkg::DATA_WIDTH-1:0] eig_large,
	output logic signed [sje_pkg::DATA_WIDTH-1:0] eig_small,
	output logic signed [sje_pkg::DATA_WIDTH-1:0] vec_r0c0,
	output logic signed [sje_pkg::DATA_WIDTH-1:0] vec_r0c1,
	output logic signed [sje_pkg::DATA_WIDTH-1:0] vec_r1c0,
	output logic signed [sje_pkg::DATA_WIDTH-1:0] vec_r1c1
);
	import sje_pkg::*;

	localparam int N   = CORDIC_STAGES;
	localparam int DW  = DATA_WIDTH;
	localparam int LAT = 2 * N + 9;

	assign busy = 1'b0;

	// Stage 1: difference, doubled off-diagonal, magnitudes
	logic                 vld_s1;
	mat_t                 m_s1;
	logic                 eq_s1, neg_s1;
	logic [MW-1:0]        ux_s1, uy_s1, mx_s1;
	logic signed [MW-1:0] diff_c, num_c;
	logic [MW-1:0]        ux_c, uy_c;

	always_comb begin
		diff_c = MW'(entry_a) - MW'(entry_d);
		num_c  = {entry_b, 1'b0};
		ux_c   = diff_c[MW-1] ? MW'(-diff_c) : MW'(diff_c);
		uy_c   = num_c[MW-1] ? MW'(-num_c) : MW'(num_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		m_s1   <= '{a: entry_a, b: entry_b, d: entry_d};
		eq_s1  <= (diff_c == '0);
		neg_s1 <= diff_c[MW-1] != num_c[MW-1];
		ux_s1  <= ux_c;
		uy_s1  <= uy_c;
		mx_s1  <= (ux_c > uy_c) ? ux_c : uy_c;
	end

	// Stage 2: normalizing shift from the leading one of the larger magnitude
	logic           vld_s2;
	mat_t           m_s2;
	logic           eq_s2, neg_s2;
	logic [MW-1:0]  ux_s2, uy_s2;
	logic [SHW-1:0] sh_s2;
	logic [SHW-1:0] msb_c;

	always_comb begin
		msb_c = '0;
		for (int k = 0; k < MW; k++) begin
			if (mx_s1[k]) msb_c = SHW'(k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		m_s2   <= m_s1;
		eq_s2  <= eq_s1;
		neg_s2 <= neg_s1;
		ux_s2  <= ux_s1;
		uy_s2  <= uy_s1;
		sh_s2  <= SHW'(NORM_MSB) - msb_c;
	end

	// Vectoring CORDIC: entry 0 holds the normalized operands, one iteration per stage
	logic                 vv_s  [0:N];
	mat_t                 vm_s  [0:N];
	logic                 veq_s [0:N];
	logic                 vng_s [0:N];
	logic signed [VW-1:0] vx_s  [0:N];
	logic signed [VW-1:0] vy_s  [0:N];
	logic signed [ZW-1:0] vz_s  [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vv_s[0] <= 1'b0;
		else vv_s[0] <= vld_s2;
	end

	always_ff @(posedge clk) begin
		vm_s[0]  <= m_s2;
		veq_s[0] <= eq_s2;
		vng_s[0] <= neg_s2;
		vx_s[0]  <= signed'(VW'(ux_s2) << sh_s2);
		vy_s[0]  <= signed'(VW'(uy_s2) << sh_s2);
		vz_s[0]  <= '0;
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		logic signed [VW-1:0] xs, ys;
		assign xs = vx_s[i] >>> i;
		assign ys = vy_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vv_s[i+1] <= 1'b0;
			else vv_s[i+1] <= vv_s[i];
		end

		always_ff @(posedge clk) begin
			vm_s[i+1]  <= vm_s[i];
			veq_s[i+1] <= veq_s[i];
			vng_s[i+1] <= vng_s[i];
			if (!vy_s[i][VW-1]) begin
				vx_s[i+1] <= vx_s[i] + ys;
				vy_s[i+1] <= vy_s[i] - xs;
				vz_s[i+1] <= vz_s[i] + atan_step(i);
			end else begin
				vx_s[i+1] <= vx_s[i] - ys;
				vy_s[i+1] <= vy_s[i] + xs;
				vz_s[i+1] <= vz_s[i] - atan_step(i);
			end
		end
	end

	// Jacobi angle: half the vectoring angle with sign restored, pi/4 on equal diagonal
	logic signed [ZW-1:0] half_c, theta_c;

	always_comb begin
		half_c  = vz_s[N] >>> 1;
		theta_c = veq_s[N] ? ANG_PI4 : (vng_s[N] ? -half_c : half_c);
	end

	// Rotation CORDIC: entry 0 loads 1/K and the angle
	logic                 rv_s [0:N];
	mat_t                 rm_s [0:N];
	logic signed [ZW-1:0] rx_s [0:N];
	logic signed [ZW-1:0] ry_s [0:N];
	logic signed [ZW-1:0] rz_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_s[0] <= 1'b0;
		else rv_s[0] <= vv_s[N];
	end

	always_ff @(posedge clk) begin
		rm_s[0] <= vm_s[N];
		rx_s[0] <= CORDIC_KINV;
		ry_s[0] <= '0;
		rz_s[0] <= theta_c;
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		logic signed [ZW-1:0] xs, ys;
		assign xs = rx_s[i] >>> i;
		assign ys = ry_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv_s[i+1] <= 1'b0;
			else rv_s[i+1] <= rv_s[i];
		end

		always_ff @(posedge clk) begin
			rm_s[i+1] <= rm_s[i];
			if (!rz_s[i][ZW-1]) begin
				rx_s[i+1] <= rx_s[i] - ys;
				ry_s[i+1] <= ry_s[i] + xs;
				rz_s[i+1] <= rz_s[i] - atan_step(i);
			end else begin
				rx_s[i+1] <= rx_s[i] + ys;
				ry_s[i+1] <= ry_s[i] - xs;
				rz_s[i+1] <= rz_s[i] + atan_step(i);
			end
		end
	end

	// Stage 5: clamp cos/sin to [-1, 1]
	logic                 vld_s5;
	mat_t                 m_s5;
	logic signed [DW-1:0] c_s5, s_s5;

	function automatic logic signed [DW-1:0] clamp_q30(input logic signed [ZW-1:0] v);
		logic signed [ZW-1:0] r;
		if (v > ONE_Q30) r = ONE_Q30;
		else if (v < -ONE_Q30) r = -ONE_Q30;
		else r = v;
		return DW'(r);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else vld_s5 <= rv_s[N];
	end

	always_ff @(posedge clk) begin
		m_s5 <= rm_s[N];
		c_s5 <= clamp_q30(rx_s[N]);
		s_s5 <= clamp_q30(ry_s[N]);
	end

	// Stage 6: c^2, s^2, sin(2theta)
	logic                   vld_s6;
	mat_t                   m_s6;
	logic signed [DW-1:0]   c_s6, s_s6;
	logic signed [DW-1:0]   c2_s6, s2_s6;
	logic signed [DW:0]     sin2_s6;
	logic signed [2*DW-1:0] cc_c, ss_c, cs_c;

	always_comb begin
		cc_c = (2*DW)'(c_s5) * (2*DW)'(c_s5);
		ss_c = (2*DW)'(s_s5) * (2*DW)'(s_s5);
		cs_c = (2*DW)'(c_s5) * (2*DW)'(s_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		m_s6    <= m_s5;
		c_s6    <= c_s5;
		s_s6    <= s_s5;
		c2_s6   <= DW'(cc_c >>> FRAC_ANG);
		s2_s6   <= DW'(ss_c >>> FRAC_ANG);
		sin2_s6 <= (DW+1)'(cs_c >>> (FRAC_ANG - 1));
	end

	// Stage 7: matrix entries times rotation terms
	localparam int PW = DW + 3;
	logic                   vld_s7;
	logic signed [DW-1:0]   c_s7, s_s7;
	logic signed [PW-1:0]   ac2_s7, ds2_s7, dc2_s7, as2_s7, bt_s7;
	logic signed [2*DW-1:0] ac2_c, ds2_c, dc2_c, as2_c;
	logic signed [2*DW:0]   bt_c;

	always_comb begin
		ac2_c = (2*DW)'(m_s6.a) * (2*DW)'(c2_s6);
		ds2_c = (2*DW)'(m_s6.d) * (2*DW)'(s2_s6);
		dc2_c = (2*DW)'(m_s6.d) * (2*DW)'(c2_s6);
		as2_c = (2*DW)'(m_s6.a) * (2*DW)'(s2_s6);
		bt_c  = (2*DW+1)'(m_s6.b) * (2*DW+1)'(sin2_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		c_s7   <= c_s6;
		s_s7   <= s_s6;
		ac2_s7 <= PW'(ac2_c >>> FRAC_ANG);
		ds2_s7 <= PW'(ds2_c >>> FRAC_ANG);
		dc2_s7 <= PW'(dc2_c >>> FRAC_ANG);
		as2_s7 <= PW'(as2_c >>> FRAC_ANG);
		bt_s7  <= PW'(bt_c >>> FRAC_ANG);
	end

	// Stage 8: rotated diagonal values and ordering decision
	localparam int EW = PW + 2;
	logic                 vld_s8;
	logic signed [DW-1:0] c_s8, s_s8;
	logic signed [EW-1:0] e0_s8, e1_s8;
	logic                 swap_s8;
	logic signed [EW-1:0] e0_c, e1_c;

	always_comb begin
		e0_c = EW'(ac2_s7) + EW'(ds2_s7) + EW'(bt_s7);
		e1_c = EW'(dc2_s7) + EW'(as2_s7) - EW'(bt_s7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		c_s8    <= c_s7;
		s_s8    <= s_s7;
		e0_s8   <= e0_c;
		e1_s8   <= e1_c;
		swap_s8 <= e1_c > e0_c;
	end

	// Output stage: swap, saturate, register results
	function automatic logic signed [DW-1:0] sat_data(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] hi, lo;
		logic signed [DW-1:0] r;
		hi = EW'({1'b0, {(DW-1){1'b1}}});
		lo = -hi - EW'(1);
		if (v > hi) r = {1'b0, {(DW-1){1'b1}}};
		else if (v < lo) r = {1'b1, {(DW-1){1'b0}}};
		else r = DW'(v);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_s8;
	end

	always_ff @(posedge clk) begin
		if (swap_s8) begin
			eig_large <= sat_data(e1_s8);
			eig_small <= sat_data(e0_s8);
			vec_r0c0  <= s_s8;
			vec_r0c1  <= c_s8;
			vec_r1c0  <= -c_s8;
			vec_r1c1  <= s_s8;
		end else begin
			eig_large <= sat_data(e0_s8);
			eig_small <= sat_data(e1_s8);
			vec_r0c0  <= c_s8;
			vec_r0c1  <= s_s8;
			vec_r1c0  <= s_s8;
			vec_r1c1  <= -c_s8;
		end
	end

	// Checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result strobe missing at pipeline latency");

	a_offdiag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (vec_r0c1 == vec_r1c0) || (vec_r0c1 == -vec_r1c0))
		else $error("eigenvector off-diagonal pair inconsistent");

	a_diag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (vec_r0c0 == vec_r1c1) || (vec_r0c0 == -vec_r1c1))
		else $error("eigenvector diagonal pair inconsistent");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> eig_large >= eig_small)
		else $error("eigenvalues out of order");

endmodule
